>>> rtl/core/lbf_pkg.sv
// lbf_pkg: shared types and constants of the lookup-table bilateral filter
// used by every module under rtl/core, depends on nothing
`timescale 1ns / 1ps
package lbf_pkg;

  localparam int PIX_W      = 16;
  localparam int CMD_W      = 2;
  localparam int TIDX_W     = 8;
  localparam int TVAL_W     = 16;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int RAD_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [FW_W-1:0]  FW_RESET  = 11'd1024;
  localparam logic [FH_W-1:0]  FH_RESET  = 16'd1024;
  localparam logic [RAD_W-1:0] RAD_RESET = 3'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL   = 2'd0,
    CMD_RANGE   = 2'd1,
    CMD_SPATIAL = 2'd2,
    CMD_DRAIN   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              range_we;
    logic              spatial_we;
    logic [TIDX_W-1:0] idx;
    logic [TVAL_W-1:0] val;
  } tbl_wr_t;

  typedef struct packed {
    logic clear;
    logic tap_valid;
  } acc_ctl_t;

endpackage

>>> rtl/core/lbf_line_store.sv
// lbf_line_store: ring of line rows holding the recent pixels of the frame
// one write port, one registered read port; uses lbf_pkg
`timescale 1ns / 1ps
module lbf_line_store #(
  parameter int MAX_WIDTH = 1024,
  parameter int LINE_ROWS = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(LINE_ROWS)-1:0]      wr_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]      wr_col,
  input  logic [lbf_pkg::PIX_W-1:0]         wdata,
  input  logic [$clog2(LINE_ROWS)-1:0]      rd_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]      rd_col,
  output logic [lbf_pkg::PIX_W-1:0]         rdata
);
  import lbf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = LINE_ROWS << CW;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[{wr_row, wr_col}] <= wdata;
    end
    rdata <= mem[{rd_row, rd_col}];
  end

endmodule

>>> rtl/core/lbf_weight_acc.sv
// lbf_weight_acc: weight tables and the per-tap pipeline
// range index, weight product, and the weight and value sums; uses lbf_pkg
`timescale 1ns / 1ps
module lbf_weight_acc #(
  parameter int TAPS          = 225,
  parameter int RANGE_ENTRIES = 256,
  parameter int WSUM_W        = 24,
  parameter int VSUM_W        = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lbf_pkg::tbl_wr_t               tbl,
  input  lbf_pkg::acc_ctl_t              ctl,
  input  logic [$clog2(TAPS)-1:0]        tap_idx,
  input  logic [lbf_pkg::PIX_W-1:0]      centre,
  input  logic [lbf_pkg::PIX_W-1:0]      nb_data,
  output logic                           busy,
  output logic [WSUM_W-1:0]              wsum,
  output logic [VSUM_W-1:0]              vsum
);
  import lbf_pkg::*;

  localparam int TW  = $clog2(TAPS);
  localparam int RIW = $clog2(RANGE_ENTRIES);
  localparam int PW  = PIX_W + RIW;

  logic [PIX_W-1:0] range_mem   [RANGE_ENTRIES];
  logic [PIX_W-1:0] spatial_mem [TAPS];

  logic [PIX_W-1:0] sp_rd;
  logic [PIX_W-1:0] rg_rd;
  logic [RIW-1:0]   ri;

  logic             v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [PW-1:0]    p1_r;
  logic [PIX_W-1:0] nb1_r, sp1_r, nb2_r, sp2_r, nb3_r;
  logic [PIX_W-1:0] wt3_r, wt4_r;
  logic [2*PIX_W-1:0] prod4_r;
  logic [WSUM_W-1:0]  wsum_r;
  logic [VSUM_W-1:0]  vsum_r;

  logic [PIX_W-1:0]   diff;
  logic [PW-1:0]      p1_nxt;
  logic [RIW-1:0]     q;
  logic [PIX_W:0]     remv;
  logic [RIW:0]       qc;
  logic [2*PIX_W-1:0] wprod;

  always_ff @(posedge clk) begin
    if (tbl.range_we && (int'(tbl.idx) < RANGE_ENTRIES)) begin
      range_mem[RIW'(tbl.idx)] <= tbl.val;
    end
    if (tbl.spatial_we && (int'(tbl.idx) < TAPS)) begin
      spatial_mem[TW'(tbl.idx)] <= tbl.val;
    end
    sp_rd <= spatial_mem[tap_idx];
    rg_rd <= range_mem[ri];
  end

  always_comb begin
    diff   = (nb_data > centre) ? (nb_data - centre) : (centre - nb_data);
    p1_nxt = PW'(diff) * PW'(RANGE_ENTRIES - 1);
    // floor(p / 65535): quotient by shift, one correction step
    q      = p1_r[PW-1:PIX_W];
    remv   = {1'b0, p1_r[PIX_W-1:0]} + (PIX_W+1)'(q);
    qc     = {1'b0, q} + ((remv >= (PIX_W+1)'(65535)) ? (RIW+1)'(1) : (RIW+1)'(0));
    ri     = (int'(qc) > RANGE_ENTRIES - 1) ? RIW'(RANGE_ENTRIES - 1) : qc[RIW-1:0];
    wprod  = sp2_r * rg_rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= ctl.tap_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r    <= p1_nxt;
    nb1_r   <= nb_data;
    sp1_r   <= sp_rd;
    nb2_r   <= nb1_r;
    sp2_r   <= sp1_r;
    nb3_r   <= nb2_r;
    wt3_r   <= wprod[2*PIX_W-1:PIX_W];
    wt4_r   <= wt3_r;
    prod4_r <= wt3_r * nb3_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      wsum_r <= '0;
      vsum_r <= '0;
    end else if (v5_r) begin
      wsum_r <= wsum_r + WSUM_W'(wt4_r);
      vsum_r <= vsum_r + VSUM_W'(prod4_r);
    end
  end

  assign busy = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign wsum = wsum_r;
  assign vsum = vsum_r;

endmodule

>>> rtl/core/lbf_divider.sv
// lbf_divider: restoring divider, one quotient bit per cycle
// the quotient is known to fit in QW bits; uses lbf_pkg
`timescale 1ns / 1ps
module lbf_divider #(
  parameter int QW  = 16,
  parameter int DVW = 24,
  parameter int DDW = 40
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DDW-1:0] dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [QW-1:0]  quotient
);
  import lbf_pkg::*;

  localparam int CNTW = $clog2(QW + 1);

  logic [DDW-1:0]  rem_r;
  logic [DDW-1:0]  dsh_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic            fits;

  assign fits = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(QW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= DDW'(divisor) << (QW - 1);
      q_r   <= '0;
    end else if (run_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[QW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> rtl/core/lut_bilateral_filter.sv
// lut_bilateral_filter: top level of the lookup-table bilateral filter
// control sequencer and counters; uses lbf_pkg, lbf_line_store,
// lbf_weight_acc and lbf_divider
//
// use: pixels, table writes and drain ticks come in on the in_ stream, the
// kind in in_tuser. table writes load the range and spatial weight tables
// before a frame. a pixel is written into the line ring; once r rows and r
// pixels beyond a centre have arrived that centre is filtered and one result
// leaves on the out_ stream, out_tlast marking the last one of the frame.
// drain ticks give the remaining results once the whole frame is in.
// steps of a filtering request: accepting it, fetching the centre, a row
// setup (reflect, multiply, modulo) per window row, one line-store read per
// tap, draining the weight pipeline, the division and the output; each
// reflection pass at a frame border adds a step, and a zero weight sum
// skips the division. the single line-store read port sets the tap rate.
// table writes and requests with no result do not leave the idle state.
// reset (rst_n low, synchronous) restores the registers and clears the
// frame counters; the tables and the line ring stay unwritten. a stalled
// receiver holds the result in the output register; the next request is
// taken, and its result waits until the register frees. a cfg_ write to
// width, height or radius restarts the frame; one to REG_NONE does not.
`timescale 1ns / 1ps
module lut_bilateral_filter #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_RADIUS    = 7,
  parameter int RANGE_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pixel[15:0], table_index[23:16], table_value[39:24]
  input  logic [lbf_pkg::IN_DATA_W-1:0]       in_tdata,
  // command[1:0]
  input  logic [lbf_pkg::CMD_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // filtered[15:0]
  output logic [lbf_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lbf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lbf_pkg::*;

  localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int SIDE      = 2 * MAX_RADIUS + 1;
  localparam int TAPS      = SIDE * SIDE;
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(LINE_ROWS);
  localparam int TW        = $clog2(TAPS);
  localparam int RDW       = $clog2(MAX_RADIUS + 1);
  localparam int DW        = $clog2(SIDE);
  localparam int CNT_W     = CW + 16;
  localparam int WSUM_W    = PIX_W + $clog2(TAPS + 1);
  localparam int VSUM_W    = WSUM_W + PIX_W;
  localparam int YW        = 19;
  localparam int XW        = CW + 3;
  localparam int RSH       = 20;
  localparam int RECIP     = (1 << RSH) / LINE_ROWS;
  localparam int RPW       = PIX_W + RSH;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_CENTRE = 10'b0000000010,
    ST_CWAIT  = 10'b0000000100,
    ST_ROWREF = 10'b0000001000,
    ST_ROWMUL = 10'b0000010000,
    ST_ROWMOD = 10'b0000100000,
    ST_TAP    = 10'b0001000000,
    ST_FLUSH  = 10'b0010000000,
    ST_DIV    = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [RAD_W-1:0] rad_r;
  logic             cfg_pend_r;

  logic [CW:0]      w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [RDW-1:0]   r_eff;
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] lag_r;

  logic [CNT_W-1:0] pr_r, rg_r;
  logic [CW-1:0]    wcol_r, ox_r;
  logic [RW-1:0]    wrow_r, orow_r, rrow_r;
  logic [FH_W-1:0]  oy_r;

  logic signed [YW-1:0] ycur_r, ry_r;
  logic signed [XW-1:0] xcur_r, rx_r;
  logic [DW-1:0]        dy_r, dx_r;
  logic [TW-1:0]        tap_r;
  logic [RPW-1:0]       rprod_r;
  logic [PIX_W-1:0]     centre_r;
  logic [PIX_W-1:0]     result_r;

  logic                  out_valid_r;
  logic [PIX_W-1:0]      out_data_r;
  logic                  out_last_r;

  logic                  accept;
  cmd_t                  cmd;
  logic [PIX_W-1:0]      in_pixel;
  tbl_wr_t               tbl;
  acc_ctl_t              ctl;
  logic                  pix_take;
  logic                  drain_take;
  logic                  start_filter;

  logic [PIX_W-1:0]      ls_rdata;
  logic [RW-1:0]         rd_row;
  logic [CW-1:0]         rd_col;
  logic                  acc_busy;
  logic [WSUM_W-1:0]     wsum;
  logic [VSUM_W-1:0]     vsum;
  logic                  div_start;
  logic                  div_done;
  logic [PIX_W-1:0]      div_q;

  logic signed [YW-1:0]  hn;
  logic signed [XW-1:0]  wn;
  logic                  ry_in, rx_in;
  logic signed [YW-1:0]  ry_a, ry_step;
  logic signed [XW-1:0]  rx_a, rx_step;
  logic [DW:0]           r2;
  logic [PIX_W-1:0]      rq;
  logic [21:0]           remv;
  logic [21:0]           remc;
  logic                  out_free;
  logic                  last_res;

  // effective frame geometry
  always_comb begin
    if (fw_r < FW_W'(2)) begin
      w_eff = (CW+1)'(2);
    end else if (int'(fw_r) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(fw_r);
    end
    h_eff = (fh_r < FH_W'(2)) ? FH_W'(2) : fh_r;
    r_eff = (int'(rad_r) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(rad_r);
  end

  always_ff @(posedge clk) begin
    total_r <= CNT_W'(w_eff) * CNT_W'(h_eff);
    lag_r   <= CNT_W'(r_eff) * CNT_W'(w_eff) + CNT_W'(r_eff);
  end

  assign accept   = in_tvalid & in_tready;
  assign cmd      = cmd_t'(in_tuser);
  assign in_pixel = in_tdata[15:0];
  assign in_tready = rst_n && (state_r == ST_IDLE) && !cfg_pend_r;

  always_comb begin
    tbl.range_we   = accept && (cmd == CMD_RANGE);
    tbl.spatial_we = accept && (cmd == CMD_SPATIAL);
    tbl.idx        = in_tdata[23:16];
    tbl.val        = in_tdata[39:24];
  end

  assign pix_take   = accept && (cmd == CMD_PIXEL) && (pr_r < total_r);
  assign drain_take = accept && (cmd == CMD_DRAIN) && (pr_r >= total_r) && (rg_r < total_r);
  assign start_filter = drain_take ||
                        (pix_take && ({1'b0, pr_r} >= ({1'b0, rg_r} + {1'b0, lag_r})));

  // reflect-101, one pass per cycle until inside
  always_comb begin
    hn      = YW'(signed'({1'b0, h_eff}));
    wn      = XW'(signed'({1'b0, w_eff}));
    ry_in   = (ry_r >= 0) && (ry_r < hn);
    rx_in   = (rx_r >= 0) && (rx_r < wn);
    ry_a    = (ry_r < 0) ? -ry_r : ry_r;
    ry_step = (ry_a >= hn) ? (hn + hn - YW'(2) - ry_a) : ry_a;
    rx_a    = (rx_r < 0) ? -rx_r : rx_r;
    rx_step = (rx_a >= wn) ? (wn + wn - XW'(2) - rx_a) : rx_a;
    r2      = {1'b0, r_eff, 1'b0};
    // row mod by reciprocal, one correction
    rq      = rprod_r[RPW-1:RSH];
    remv    = 22'(ry_r[PIX_W-1:0]) - 22'(rq * 22'(LINE_ROWS));
    remc    = (remv >= 22'(LINE_ROWS)) ? (remv - 22'(LINE_ROWS)) : remv;
    out_free = !out_valid_r || out_tready;
    last_res = ({1'b0, rg_r} + (CNT_W+1)'(1)) >= {1'b0, total_r};
  end

  always_comb begin
    state_nxt = state_r;
    ctl.clear     = 1'b0;
    ctl.tap_valid = 1'b0;
    div_start     = 1'b0;
    rd_row        = rrow_r;
    rd_col        = rx_r[CW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (start_filter) begin
          state_nxt = ST_CENTRE;
        end
      end
      ST_CENTRE: begin
        rd_row    = orow_r;
        rd_col    = ox_r;
        ctl.clear = 1'b1;
        state_nxt = ST_CWAIT;
      end
      ST_CWAIT: begin
        state_nxt = ST_ROWREF;
      end
      ST_ROWREF: begin
        if (ry_in) begin
          state_nxt = ST_ROWMUL;
        end
      end
      ST_ROWMUL: begin
        state_nxt = ST_ROWMOD;
      end
      ST_ROWMOD: begin
        state_nxt = ST_TAP;
      end
      ST_TAP: begin
        if (rx_in) begin
          ctl.tap_valid = 1'b1;
          if ({1'b0, dx_r} == r2) begin
            state_nxt = ({1'b0, dy_r} == r2) ? ST_FLUSH : ST_ROWREF;
          end
        end
      end
      ST_FLUSH: begin
        if (!acc_busy) begin
          if (wsum == '0) begin
            state_nxt = ST_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fw_r        <= FW_RESET;
      fh_r        <= FH_RESET;
      rad_r       <= RAD_RESET;
      cfg_pend_r  <= 1'b0;
      pr_r        <= '0;
      rg_r        <= '0;
      wcol_r      <= '0;
      wrow_r      <= '0;
      ox_r        <= '0;
      oy_r        <= '0;
      orow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cfg_pend_r <= cfg_we;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && (reg_idx_t'(cfg_index) != REG_NONE)) begin
        case (reg_idx_t'(cfg_index))
          REG_WIDTH:  fw_r  <= cfg_wdata[FW_W-1:0];
          REG_HEIGHT: fh_r  <= cfg_wdata[FH_W-1:0];
          REG_RADIUS: rad_r <= cfg_wdata[RAD_W-1:0];
          default:    fw_r  <= fw_r;
        endcase
        pr_r   <= '0;
        rg_r   <= '0;
        wcol_r <= '0;
        wrow_r <= '0;
        ox_r   <= '0;
        oy_r   <= '0;
        orow_r <= '0;
      end else begin
        if (pix_take) begin
          pr_r <= pr_r + CNT_W'(1);
          if ({1'b0, wcol_r} == w_eff - (CW+1)'(1)) begin
            wcol_r <= '0;
            wrow_r <= (int'(wrow_r) == LINE_ROWS - 1) ? '0 : wrow_r + RW'(1);
          end else begin
            wcol_r <= wcol_r + CW'(1);
          end
        end
        if (state_r == ST_OUT && out_free) begin
          if (last_res) begin
            rg_r   <= '0;
            pr_r   <= '0;
            wcol_r <= '0;
            wrow_r <= '0;
            ox_r   <= '0;
            oy_r   <= '0;
            orow_r <= '0;
          end else begin
            rg_r <= rg_r + CNT_W'(1);
            if ({1'b0, ox_r} == w_eff - (CW+1)'(1)) begin
              ox_r   <= '0;
              oy_r   <= oy_r + FH_W'(1);
              orow_r <= (int'(orow_r) == LINE_ROWS - 1) ? '0 : orow_r + RW'(1);
            end else begin
              ox_r <= ox_r + CW'(1);
            end
          end
        end
      end
    end
  end

  // window walk and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_CWAIT: begin
        centre_r <= ls_rdata;
        dy_r     <= '0;
        ycur_r   <= YW'(signed'({1'b0, oy_r})) - YW'(signed'({1'b0, r_eff}));
        ry_r     <= YW'(signed'({1'b0, oy_r})) - YW'(signed'({1'b0, r_eff}));
        tap_r    <= '0;
      end
      ST_ROWREF: begin
        if (!ry_in) begin
          ry_r <= ry_step;
        end
      end
      ST_ROWMUL: begin
        rprod_r <= RPW'(ry_r[PIX_W-1:0]) * RPW'(RECIP);
      end
      ST_ROWMOD: begin
        rrow_r <= remc[RW-1:0];
        dx_r   <= '0;
        xcur_r <= XW'(signed'({1'b0, ox_r})) - XW'(signed'({1'b0, r_eff}));
        rx_r   <= XW'(signed'({1'b0, ox_r})) - XW'(signed'({1'b0, r_eff}));
      end
      ST_TAP: begin
        if (!rx_in) begin
          rx_r <= rx_step;
        end else begin
          tap_r  <= tap_r + TW'(1);
          dx_r   <= dx_r + DW'(1);
          xcur_r <= xcur_r + XW'(1);
          rx_r   <= xcur_r + XW'(1);
          if ({1'b0, dx_r} == r2) begin
            dy_r   <= dy_r + DW'(1);
            ycur_r <= ycur_r + YW'(1);
            ry_r   <= ycur_r + YW'(1);
          end
        end
      end
      ST_FLUSH: begin
        result_r <= centre_r;
      end
      ST_DIV: begin
        result_r <= div_q;
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_r <= result_r;
          out_last_r <= last_res;
        end
      end
      default: begin
        result_r <= result_r;
      end
    endcase
  end

  lbf_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .LINE_ROWS (LINE_ROWS)
  ) u_line (
    .clk    (clk),
    .we     (pix_take),
    .wr_row (wrow_r),
    .wr_col (wcol_r),
    .wdata  (in_pixel),
    .rd_row (rd_row),
    .rd_col (rd_col),
    .rdata  (ls_rdata)
  );

  lbf_weight_acc #(
    .TAPS          (TAPS),
    .RANGE_ENTRIES (RANGE_ENTRIES),
    .WSUM_W        (WSUM_W),
    .VSUM_W        (VSUM_W)
  ) u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .tbl     (tbl),
    .ctl     (ctl),
    .tap_idx (tap_r),
    .centre  (centre_r),
    .nb_data (ls_rdata),
    .busy    (acc_busy),
    .wsum    (wsum),
    .vsum    (vsum)
  );

  lbf_divider #(
    .QW  (PIX_W),
    .DVW (WSUM_W),
    .DDW (VSUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (vsum),
    .divisor  (wsum),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> test/tb_top.sv
// tb_top: self-checking testbench of lut_bilateral_filter, streams table loads, pixels
// and drain ticks, predicts every filtered pixel and compares it; imports only lbf_pkg
`timescale 1ns / 1ps
module tb_top;
  import lbf_pkg::*;

  localparam int  LINE_ROWS  = 16;
  localparam int  MAXW       = 1024;
  localparam int  TAP_COUNT  = 225;
  localparam int  N_RANDOM   = 1300;
  localparam int  DRAIN_WAIT = 400;
  localparam longint LIMIT   = 6000000;

  class bilateral_scoreboard;
    logic [15:0] line_mem [0:LINE_ROWS*MAXW-1];
    logic [15:0] range_w [0:255];
    logic [15:0] spatial_w [0:TAP_COUNT-1];
    int unsigned width_reg, height_reg, radius_reg;
    int unsigned pix_count, res_count;
    logic [15:0] expected_filtered [$];
    logic        expected_frame_end [$];
    int errors;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (range_w[i]) range_w[i] = '0;
      foreach (spatial_w[i]) spatial_w[i] = '0;
      width_reg = 1024; height_reg = 1024; radius_reg = 2;
      pix_count = 0; res_count = 0; errors = 0;
    endfunction

    function int unsigned eff_w();
      return width_reg < 2 ? 2 : (width_reg > MAXW ? MAXW : width_reg);
    endfunction

    function int unsigned eff_h();
      return height_reg < 2 ? 2 : height_reg;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_WIDTH: width_reg = v[10:0];
        REG_HEIGHT: height_reg = v;
        REG_RADIUS: radius_reg = v[2:0];
        default: return;
      endcase
      pix_count = 0;
      res_count = 0;
    endfunction

    function int reflect(int i, int n);
      while (i < 0 || i >= n) begin
        if (i < 0) i = -i;
        if (i >= n) i = 2 * n - 2 - i;
      end
      return i;
    endfunction

    function logic [15:0] predict_filtered(int k, int w, int h, int r);
      int y, x, dy, dx, ry, rx, tap;
      int unsigned centre, nb, diff, ri, wt;
      longint unsigned wsum, vsum;
      y = k / w; x = k % w;
      centre = line_mem[(y % LINE_ROWS) * MAXW + x];
      wsum = 0; vsum = 0;
      for (dy = -r; dy <= r; dy++) begin
        ry = reflect(y + dy, h);
        for (dx = -r; dx <= r; dx++) begin
          rx = reflect(x + dx, w);
          nb = line_mem[(ry % LINE_ROWS) * MAXW + rx];
          diff = nb > centre ? nb - centre : centre - nb;
          ri = (diff * 255) / 65535;
          tap = (dy + r) * (2 * r + 1) + (dx + r);
          wt = (spatial_w[tap] * range_w[ri]) >> 16;
          wsum += wt;
          vsum += longint'(wt) * nb;
        end
      end
      if (wsum == 0) return centre[15:0];
      return 16'(vsum / wsum);
    endfunction

    function void emit_result(int unsigned w, int unsigned h, int unsigned r);
      expected_filtered.push_back(predict_filtered(res_count, w, h, r));
      res_count++;
      if (res_count >= w * h) begin
        expected_frame_end.push_back(1'b1);
        res_count = 0;
        pix_count = 0;
      end else begin
        expected_frame_end.push_back(1'b0);
      end
    endfunction

    function void note_request(cmd_t cmd, logic [15:0] pix, logic [7:0] ti, logic [15:0] tv);
      int unsigned w, h, r, total, y, x;
      w = eff_w(); h = eff_h(); r = radius_reg; total = w * h;
      case (cmd)
        CMD_RANGE: range_w[ti] = tv;
        CMD_SPATIAL: if (ti < TAP_COUNT) spatial_w[ti] = tv;
        CMD_DRAIN: if (pix_count >= total && res_count < total) emit_result(w, h, r);
        default: begin
          if (pix_count < total) begin
            y = pix_count / w; x = pix_count % w;
            line_mem[(y % LINE_ROWS) * MAXW + x] = pix;
            pix_count++;
            if (pix_count >= res_count + r * w + r + 1) emit_result(w, h, r);
          end
        end
      endcase
    endfunction

    function bit drain_pending();
      return pix_count >= eff_w() * eff_h() && res_count < eff_w() * eff_h();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [15:0] d, logic last);
      logic [15:0] ef;
      logic el;
      if (expected_filtered.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      ef = expected_filtered.pop_front();
      el = expected_frame_end.pop_front();
      if (d !== ef) report($sformatf("filtered %h, want %h", d, ef));
      if (last !== el) report($sformatf("frame_end %b, want %b", last, el));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bilateral_scoreboard sb = new();
  int send_idle_pct = 9;
  int recv_idle_pct = 67;
  bit hold_go = 0;
  int hold_left = 0;
  longint cycles = 0;
  int sent = 0;

  lut_bilateral_filter dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);

  // receiver stalls, plus one long hold-off so the block backs up
  always @(negedge clk) begin
    if (hold_go && hold_left == 0) begin
      hold_go <= 0;
      hold_left <= 3000;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else begin
      out_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task send(cmd_t cmd, logic [15:0] pix, logic [7:0] ti, logic [15:0] tv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {tv, ti, pix};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, pix, ti, tv);
    sent++;
    if (sent == 900) hold_go = 1;
    if (sent == N_RANDOM / 3) begin
      send_idle_pct = 67;
      recv_idle_pct = 9;
    end else if (sent == 2 * N_RANDOM / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
  endtask

  task wait_idle();
    in_tvalid <= 0;
    while (sb.expected_filtered.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function logic [15:0] rand_pixel();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(32768 + $urandom_range(600) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  task send_pixel(logic [15:0] p);
    send(CMD_PIXEL, p, 8'($urandom), 16'($urandom));
  endtask

  task flush_frame();
    while (sb.drain_pending()) send(CMD_DRAIN, 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task set_frame(logic [15:0] w, logic [15:0] h, logic [15:0] r);
    wait_idle();
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  initial begin
    int w, h, r, n;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // every table entry gets a value before any filtering
    for (int i = 0; i < 256; i++)
      send(CMD_RANGE, 16'($urandom), 8'(i), i % 37 == 5 ? 16'h0 : 16'($urandom));
    for (int i = 0; i < TAP_COUNT; i++)
      send(CMD_SPATIAL, 16'($urandom), 8'(i), i == 0 ? 16'hFFFF : 16'($urandom));

    // directed: 3x2 frame, radius one
    set_frame(16'd3, 16'd2, 16'd1);
    write_reg(REG_NONE, 16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send(CMD_DRAIN, 16'h0, 8'h0, 16'h0);
    send_pixel(16'h8000);
    send(CMD_RANGE, 16'hFFFF, 8'hFF, 16'hFFFF);
    send(CMD_SPATIAL, 16'hFFFF, 8'hFF, 16'h0000);
    send_pixel(16'h7FFF);
    send_pixel(16'h0101);
    send_pixel(16'hFEFE);
    send_pixel(16'h1234);
    flush_frame();
    send(CMD_DRAIN, 16'h0, 8'h0, 16'h0);
    // zero weight gives the centre; width below two clamps
    send(CMD_SPATIAL, 16'h0, 8'd0, 16'h0000);
    set_frame(16'd0, 16'd1, 16'd0);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
    send(CMD_SPATIAL, 16'h0, 8'd0, 16'hFFFF);
    // all-ones width clamps to max; all-ones radius gives seven
    set_frame(16'hFFFF, 16'd2, 16'd0);
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
    set_frame(16'd16, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 140; i++) send_pixel(rand_pixel());

    while (sent < N_RANDOM) begin
      r = $urandom_range(3) == 0 ? $urandom_range(7) : $urandom_range(2);
      w = 2 * r + 1 + $urandom_range(5);
      if (w < 2) w = 2;
      h = r + 1 + $urandom_range(3);
      if (h < 2) h = 2;
      set_frame(16'(w), 16'(h), 16'(r));
      n = w * h;
      while (n > 0) begin
        case ($urandom_range(24))
          0: send(CMD_RANGE, 16'($urandom), 8'($urandom),
                  $urandom_range(7) == 0 ? 16'h0 : 16'($urandom));
          1: send(CMD_SPATIAL, 16'($urandom), 8'($urandom), 16'($urandom));
          2: send(CMD_DRAIN, 16'($urandom), 8'($urandom), 16'($urandom));
          default: begin
            send_pixel(rand_pixel());
            n--;
          end
        endcase
      end
      if ($urandom_range(3) == 0) send_pixel(rand_pixel());
      flush_frame();
      if ($urandom_range(3) == 0) send(CMD_DRAIN, 16'($urandom), 8'($urandom), 16'($urandom));
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_filtered.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> lut_bilateral_filter.f
rtl/core/lbf_pkg.sv
rtl/core/lbf_line_store.sv
rtl/core/lbf_weight_acc.sv
rtl/core/lbf_divider.sv
rtl/core/lut_bilateral_filter.sv
test/tb_top.sv
